@@ hw/rtl/srt_pkg.sv @@
// Package for the shortest-remaining-time scheduler.
// Request codes, sequencer states, widths and the saturating time increment.
// No dependencies.
package srt_pkg;

  // Widths fixed by the request and result formats
  localparam int unsigned TIME_W = 32;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned WORD_W = 2 * HALF_W;
  localparam int unsigned SLOT_W = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Request codes; code 3 means nothing and is dropped
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  // Tick sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WB
  } state_t;

  // Time counter sticks at its top value
  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] r;
    r = (t == TIME_MAX) ? TIME_MAX : t + TIME_W'(1);
    return r;
  endfunction

endpackage

@@ hw/rtl/shortest_remaining_time_scheduler_top.sv @@
// Shortest-remaining-time scheduler: job table in RAM, one slot scanned per cycle.
// Load and clear requests complete in the cycle they are accepted.
// A tick reads one RAM word per slot, makes the last compare, then writes back and loads
// the result register. The next tick waits until the result register is free.
// Reset empties the table (valid bits cleared at once) and zeroes the time; needs srt_ram.
module shortest_remaining_time_scheduler_top #(
  parameter int JOB_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_slot,
  input  logic [15:0] in_arrival_time,
  input  logic [15:0] in_burst_time,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_tick_time,
  output logic        out_idle,
  output logic [3:0]  out_run_slot,
  output logic        out_job_finished,
  output logic [31:0] out_end_time,
  output logic        out_all_done
);

  localparam int IDX_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(JOB_SLOTS - 1);

  srt_pkg::state_t state_r, state_nxt;

  logic [JOB_SLOTS-1:0]          valid_r;
  logic [srt_pkg::TIME_W-1:0]    now_r;
  logic [IDX_W-1:0]              rd_idx_r;
  logic [IDX_W-1:0]              cmp_idx_r;
  logic                          cmp_vld_r;
  logic                          found_r;
  logic                          work_r;
  logic [IDX_W-1:0]              best_idx_r;
  logic [srt_pkg::HALF_W-1:0]    best_rem_r;
  logic [srt_pkg::HALF_W-1:0]    best_arr_r;

  logic                          out_valid_r;
  logic [srt_pkg::TIME_W-1:0]    out_tick_time_r;
  logic                          out_idle_r;
  logic [srt_pkg::SLOT_W-1:0]    out_run_slot_r;
  logic                          out_job_finished_r;
  logic [srt_pkg::TIME_W-1:0]    out_end_time_r;
  logic                          out_all_done_r;

  // RAM port signals
  logic                          ram_wr_en;
  logic [IDX_W-1:0]              ram_wr_addr;
  logic [srt_pkg::WORD_W-1:0]    ram_wr_data;
  logic                          ram_rd_en;
  logic [srt_pkg::WORD_W-1:0]    ram_rd_data;

  logic                          in_acc;
  logic                          slot_in_range;
  logic                          is_load, is_tick, is_clear;
  logic [srt_pkg::HALF_W-1:0]    rd_arr, rd_rem;
  logic                          cand_work, cand_ready, cand_better;
  logic                          fin_now;

  // Arrival in the upper half of a word, remaining time in the lower half
  srt_ram #(
    .WIDTH (srt_pkg::WORD_W),
    .DEPTH (JOB_SLOTS)
  ) u_job_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rd_data)
  );

  // Request decode
  assign is_load  = (in_req_type == srt_pkg::REQ_LOAD);
  assign is_tick  = (in_req_type == srt_pkg::REQ_TICK);
  assign is_clear = (in_req_type == srt_pkg::REQ_CLEAR);
  assign slot_in_range = (int'(in_slot) < JOB_SLOTS);
  assign in_acc = in_valid && !in_stall;

  // Candidate compare on the word read last cycle
  assign rd_arr = ram_rd_data[srt_pkg::WORD_W-1:srt_pkg::HALF_W];
  assign rd_rem = ram_rd_data[srt_pkg::HALF_W-1:0];
  assign cand_work  = cmp_vld_r && valid_r[cmp_idx_r] && (rd_rem != '0);
  assign cand_ready = cand_work &&
                      ({{(srt_pkg::TIME_W - srt_pkg::HALF_W){1'b0}}, rd_arr} <= now_r);
  assign cand_better = cand_ready && (!found_r || (rd_rem < best_rem_r));

  assign fin_now = found_r && (best_rem_r == srt_pkg::HALF_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srt_pkg::ST_IDLE: if (in_acc && is_tick) state_nxt = srt_pkg::ST_SCAN;
      srt_pkg::ST_SCAN: if (rd_idx_r == LAST_IDX) state_nxt = srt_pkg::ST_LAST;
      srt_pkg::ST_LAST: state_nxt = srt_pkg::ST_WB;
      srt_pkg::ST_WB:   state_nxt = srt_pkg::ST_IDLE;
      default:          state_nxt = srt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: request stall, RAM read and write ports
  always_comb begin
    in_stall    = 1'b1;
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = best_idx_r;
    ram_wr_data = {best_arr_r, best_rem_r - srt_pkg::HALF_W'(1)};
    unique case (state_r)
      srt_pkg::ST_IDLE: begin
        // a tick waits until the result register is free
        in_stall    = out_valid_r && is_tick;
        ram_wr_en   = in_acc && is_load && slot_in_range;
        ram_wr_addr = IDX_W'(in_slot);
        ram_wr_data = {in_arrival_time, in_burst_time};
      end
      srt_pkg::ST_SCAN: ram_rd_en = 1'b1;
      srt_pkg::ST_LAST: ;
      srt_pkg::ST_WB:   ram_wr_en = found_r;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= srt_pkg::ST_IDLE;
      valid_r   <= '0;
      now_r     <= '0;
      cmp_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == srt_pkg::ST_SCAN);
      if (state_r == srt_pkg::ST_IDLE && in_acc) begin
        if (is_load && slot_in_range) begin
          valid_r[IDX_W'(in_slot)] <= 1'b1;
        end else if (is_clear) begin
          valid_r <= '0;
          now_r   <= '0;
        end
      end
      if (state_r == srt_pkg::ST_WB && work_r) begin
        now_r <= srt_pkg::sat_inc(now_r);
      end
      // result register handshake
      if (state_r == srt_pkg::ST_WB) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan pointer and running best
  always_ff @(posedge clk) begin
    if (state_r == srt_pkg::ST_IDLE && in_acc && is_tick) begin
      rd_idx_r <= '0;
      found_r  <= 1'b0;
      work_r   <= 1'b0;
    end else begin
      if (state_r == srt_pkg::ST_SCAN && rd_idx_r != LAST_IDX) begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
      if (cand_work) begin
        work_r <= 1'b1;
      end
      if (cand_better) begin
        found_r    <= 1'b1;
        best_idx_r <= cmp_idx_r;
        best_rem_r <= rd_rem;
        best_arr_r <= rd_arr;
      end
    end
    cmp_idx_r <= rd_idx_r;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state_r == srt_pkg::ST_WB) begin
      out_tick_time_r    <= now_r;
      out_idle_r         <= work_r && !found_r;
      out_run_slot_r     <= found_r ? srt_pkg::SLOT_W'(best_idx_r) : '0;
      out_job_finished_r <= fin_now;
      out_end_time_r     <= fin_now ? srt_pkg::sat_inc(now_r) : '0;
      out_all_done_r     <= !work_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tick_time    = out_tick_time_r;
  assign out_idle         = out_idle_r;
  assign out_run_slot     = out_run_slot_r;
  assign out_job_finished = out_job_finished_r;
  assign out_end_time     = out_end_time_r;
  assign out_all_done     = out_all_done_r;

  // Result register is always free when a tick completes
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srt_pkg::ST_WB) |-> !out_valid_r)
    else $error("tick result would overwrite a pending result");

  // A finished table reports nothing run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_all_done) |-> (!out_idle && !out_job_finished && out_run_slot == '0))
    else $error("all_done result carries a run");

  // A finished job never reports a zero finish time
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_job_finished) |-> (out_end_time != '0 && !out_idle))
    else $error("finished job with bad finish time");

  // Time holds during a scan; it only moves after write-back or on a clear
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srt_pkg::ST_SCAN) |=> $stable(now_r))
    else $error("time changed during a scan");

endmodule

@@ hw/rtl/srt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module srt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

@@ sim/shortest_remaining_time_scheduler_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the shortest-remaining-time scheduler top level.
// It sends load, tick, clear and unknown requests, predicts every tick report and checks each one.
// Depends on srt_pkg and shortest_remaining_time_scheduler_top.
module shortest_remaining_time_scheduler_top_tb;

  localparam int         NUM_SLOTS      = 16;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 2 * (NUM_SLOTS + 3);
  localparam int         REPORT_LIMIT   = 10;
  localparam logic [1:0] REQ_UNKNOWN    = 2'd3;

  typedef struct {
    logic [31:0] tick_time;
    logic        idle;
    logic [3:0]  run_slot;
    logic        job_finished;
    logic [31:0] end_time;
    logic        all_done;
  } tick_report_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [3:0]  in_slot;
  logic [15:0] in_arrival_time;
  logic [15:0] in_burst_time;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_tick_time;
  logic        out_idle;
  logic [3:0]  out_run_slot;
  logic        out_job_finished;
  logic [31:0] out_end_time;
  logic        out_all_done;

  // Predicted job table and time
  bit          job_live [NUM_SLOTS];
  logic [15:0] job_arrival [NUM_SLOTS];
  logic [15:0] job_left [NUM_SLOTS];
  logic [31:0] sched_time;
  bit          table_drained;

  tick_report_t tick_reports_q[$];
  int           mismatches;
  int           requests_sent;
  int           quiet_cycles;
  int           gap_pct;
  int           stall_pct;

  shortest_remaining_time_scheduler_top #(
    .JOB_SLOTS(NUM_SLOTS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_slot         (in_slot),
    .in_arrival_time (in_arrival_time),
    .in_burst_time   (in_burst_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tick_time   (out_tick_time),
    .out_idle        (out_idle),
    .out_run_slot    (out_run_slot),
    .out_job_finished(out_job_finished),
    .out_end_time    (out_end_time),
    .out_all_done    (out_all_done)
  );

  always #5 clk = ~clk;

  // Apply one accepted request to the predicted table; ticks queue a report
  function automatic void advance_schedule(input logic [1:0] kind, input logic [3:0] slot,
                                           input logic [15:0] arrival,
                                           input logic [15:0] burst);
    tick_report_t rep;
    bit           pending;
    bit           picked;
    int           best;
    logic [15:0]  best_left;
    logic [31:0]  next_time;
    pending   = 1'b0;
    picked    = 1'b0;
    best      = 0;
    best_left = '0;
    next_time = (sched_time == 32'hFFFF_FFFF) ? sched_time : sched_time + 32'd1;
    case (kind)
      srt_pkg::REQ_LOAD: begin
        job_live[slot]    = 1'b1;
        job_arrival[slot] = arrival;
        job_left[slot]    = burst;
      end
      srt_pkg::REQ_CLEAR: begin
        foreach (job_live[i]) job_live[i] = 1'b0;
        sched_time = '0;
      end
      srt_pkg::REQ_TICK: begin
        // shortest remaining among arrived jobs; strict compare keeps lowest slot on ties
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (job_live[i] && job_left[i] != 16'd0) begin
            pending = 1'b1;
            if (32'(job_arrival[i]) <= sched_time && (!picked || job_left[i] < best_left)) begin
              picked    = 1'b1;
              best      = i;
              best_left = job_left[i];
            end
          end
        end
        rep.tick_time    = sched_time;
        rep.idle         = 1'b0;
        rep.run_slot     = '0;
        rep.job_finished = 1'b0;
        rep.end_time     = '0;
        rep.all_done     = 1'b0;
        if (!pending) begin
          rep.all_done = 1'b1;
        end else if (!picked) begin
          rep.idle   = 1'b1;
          sched_time = next_time;
        end else begin
          job_left[best] = job_left[best] - 16'd1;
          sched_time     = next_time;
          rep.run_slot   = 4'(best);
          if (job_left[best] == 16'd0) begin
            rep.job_finished = 1'b1;
            rep.end_time     = sched_time;
          end
        end
        table_drained = rep.all_done;
        tick_reports_q.insert(tick_reports_q.size(), rep);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] got,
                                      input logic [31:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
  endfunction

  // One request on the input channel, with an optional random gap first
  task automatic send_request(input logic [1:0] kind, input logic [3:0] slot,
                              input logic [15:0] arrival, input logic [15:0] burst);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= kind;
    in_slot         <= slot;
    in_arrival_time <= arrival;
    in_burst_time   <= burst;
    do @(posedge clk); while (in_stall);
    advance_schedule(kind, slot, arrival, burst);
    if (kind != REQ_UNKNOWN) requests_sent++;
  endtask

  // Mostly short jobs arriving near the current time; a few long or empty ones
  task automatic send_random_load();
    int          pick;
    logic [15:0] burst;
    pick = $urandom_range(99);
    if (pick < 5)       burst = 16'd0;
    else if (pick < 12) burst = 16'($urandom_range(7, 60));
    else                burst = 16'($urandom_range(1, 6));
    send_request(srt_pkg::REQ_LOAD, 4'($urandom),
                 16'(sched_time) + 16'($urandom_range(0, 6)), burst);
  endtask

  // Empty table after reset, and an unknown request that must change nothing
  task automatic test_empty_table();
    send_request(srt_pkg::REQ_TICK, 4'hF, 16'hFFFF, 16'hFFFF);
    send_request(REQ_UNKNOWN, 4'hF, 16'hFFFF, 16'hFFFF);
    send_request(srt_pkg::REQ_TICK, 4'h0, 16'h0000, 16'h0000);
  endtask

  // Equal remaining time goes to the lower slot; a shorter late arrival runs ahead of a waiting job
  task automatic test_ties_and_preemption();
    send_request(srt_pkg::REQ_LOAD, 4'd15, 16'd0, 16'd2);
    send_request(srt_pkg::REQ_LOAD, 4'd3, 16'd0, 16'd2);
    send_request(srt_pkg::REQ_LOAD, 4'd7, 16'd2, 16'd1);
    repeat (6) send_request(srt_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0);
  endtask

  // Idle ticks before arrival, field extremes, zero burst, reload and clear
  task automatic test_idle_and_reload();
    send_request(srt_pkg::REQ_CLEAR, 4'hA, 16'h5555, 16'hAAAA);
    send_request(srt_pkg::REQ_LOAD, 4'd0, 16'd3, 16'd1);
    repeat (4) send_request(srt_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0);
    send_request(srt_pkg::REQ_LOAD, 4'd9, 16'hFFFF, 16'hFFFF);
    send_request(srt_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0);
    send_request(srt_pkg::REQ_LOAD, 4'd9, 16'd0, 16'd0);
    send_request(srt_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0);
    send_request(srt_pkg::REQ_LOAD, 4'd0, 16'd0, 16'hFFFF);
    send_request(srt_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0);
    send_request(srt_pkg::REQ_CLEAR, 4'd0, 16'd0, 16'd0);
    send_request(srt_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0);
  endtask

  // Well-formed runs: optional clear, a batch of loads, up to 60 ticks until drained, some loads between
  task automatic test_random_sequences(input int target);
    int ticks;
    while (requests_sent < target) begin
      if ($urandom_range(99) < 70) send_request(srt_pkg::REQ_CLEAR, 4'($urandom),
                                                16'($urandom), 16'($urandom));
      repeat ($urandom_range(1, 8)) send_random_load();
      ticks         = 0;
      table_drained = 1'b0;
      while (!table_drained && ticks < 60) begin
        send_request(srt_pkg::REQ_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
        ticks++;
        if ($urandom_range(99) < 10) send_random_load();
      end
    end
  endtask

  // Unstructured requests with every field fully random
  task automatic test_random_noise(input int target);
    while (requests_sent < target)
      send_request(2'($urandom_range(0, 3)), 4'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Result-side back-pressure in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted tick report with the oldest prediction
  always @(posedge clk) begin : check_reports
    tick_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tick_reports_q.size() == 0) begin
        note_mismatch("tick report with none expected");
      end else begin
        want = tick_reports_q.pop_front();
        check_field("tick_time", out_tick_time, want.tick_time);
        check_field("idle", 32'(out_idle), 32'(want.idle));
        check_field("run_slot", 32'(out_run_slot), 32'(want.run_slot));
        check_field("job_finished", 32'(out_job_finished), 32'(want.job_finished));
        check_field("end_time", out_end_time, want.end_time);
        check_field("all_done", 32'(out_all_done), 32'(want.all_done));
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_req_type     <= srt_pkg::REQ_LOAD;
    in_slot         <= '0;
    in_arrival_time <= '0;
    in_burst_time   <= '0;
    gap_pct         = 0;
    stall_pct       = 0;
    sched_time      = '0;
    foreach (job_live[i]) job_live[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_ties_and_preemption();
    test_idle_and_reload();

    // random phases: moderate idling, none, heavy, noise, then a calm finish
    gap_pct   = 25;
    stall_pct = 8;
    test_random_sequences(250);
    gap_pct   = 0;
    stall_pct = 0;
    test_random_sequences(330);
    gap_pct   = 50;
    stall_pct = 20;
    test_random_sequences(480);
    test_random_noise(570);
    gap_pct   = 0;
    stall_pct = 0;
    test_random_sequences(660);
    in_valid <= 1'b0;

    while (tick_reports_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
